### sv/md5hs_pkg.sv
// md5hs_pkg: shared types, constants, round tables and microcode for the md5 stream unit
package md5hs_pkg;

	// input transaction: one message byte plus framing flags
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} msg_item_t;

	// output transaction: one chaining word of the digest
	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} digest_item_t;

	// md5 initial chaining values
	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	// per-round additive constants
	localparam logic [31:0] ROUND_ADD [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// rotate amounts indexed by {group, round[1:0]}
	localparam logic [4:0] ROUND_ROT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// message word picked in a given round
	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] i;
		logic [3:0] g;
		i = rnd[3:0];
		unique case (rnd[5:4])
			2'd0: g = i;
			2'd1: g = 4'(i * 4'd5) + 4'd1;
			2'd2: g = 4'(i * 4'd3) + 4'd5;
			2'd3: g = 4'(i * 4'd7);
		endcase
		return g;
	endfunction

	// microcode
	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [3:0] {
		OP_WAIT, OP_ROUND, OP_ADD, OP_NOP, OP_PAD, OP_CLEAR, OP_LEN, OP_EMIT, OP_INIT
	} uop_t;

	typedef enum logic [2:0] {
		C_STEP, C_ALWAYS, C_NOT_LAST, C_LT56, C_DISPATCH
	} ucond_t;

	typedef struct packed {
		uop_t   op;
		ucond_t cond;
		pc_t    target;
	} uword_t;

	// program steps
	localparam pc_t PC_WAIT      = 4'd0;
	localparam pc_t PC_BLK_RND   = 4'd1;
	localparam pc_t PC_BLK_ADD   = 4'd2;
	localparam pc_t PC_TEST_LAST = 4'd3;
	localparam pc_t PC_PAD       = 4'd4;
	localparam pc_t PC_PAD_TEST  = 4'd5;
	localparam pc_t PC_XTRA_RND  = 4'd6;
	localparam pc_t PC_XTRA_ADD  = 4'd7;
	localparam pc_t PC_CLEAR     = 4'd8;
	localparam pc_t PC_LEN       = 4'd9;
	localparam pc_t PC_FIN_RND   = 4'd10;
	localparam pc_t PC_FIN_ADD   = 4'd11;
	localparam pc_t PC_EMIT      = 4'd12;
	localparam pc_t PC_INIT      = 4'd13;

	// control store: a conditional jump goes to target, else to the next step; dispatch picks its own step
	function automatic uword_t ucode_rom(input pc_t pc);
		uword_t w;
		unique case (pc)
			PC_WAIT:      w = '{OP_WAIT,  C_DISPATCH, PC_WAIT};
			PC_BLK_RND:   w = '{OP_ROUND, C_STEP,     PC_WAIT};
			PC_BLK_ADD:   w = '{OP_ADD,   C_STEP,     PC_WAIT};
			PC_TEST_LAST: w = '{OP_NOP,   C_NOT_LAST, PC_WAIT};
			PC_PAD:       w = '{OP_PAD,   C_STEP,     PC_WAIT};
			PC_PAD_TEST:  w = '{OP_NOP,   C_LT56,     PC_LEN};
			PC_XTRA_RND:  w = '{OP_ROUND, C_STEP,     PC_WAIT};
			PC_XTRA_ADD:  w = '{OP_ADD,   C_STEP,     PC_WAIT};
			PC_CLEAR:     w = '{OP_CLEAR, C_STEP,     PC_WAIT};
			PC_LEN:       w = '{OP_LEN,   C_STEP,     PC_WAIT};
			PC_FIN_RND:   w = '{OP_ROUND, C_STEP,     PC_WAIT};
			PC_FIN_ADD:   w = '{OP_ADD,   C_STEP,     PC_WAIT};
			PC_EMIT:      w = '{OP_EMIT,  C_STEP,     PC_WAIT};
			PC_INIT:      w = '{OP_INIT,  C_ALWAYS,   PC_WAIT};
			default:      w = '{OP_INIT,  C_ALWAYS,   PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

### sv/md5_hash_stream_unit.sv
// md5_hash_stream_unit: md5 over a byte stream, microcoded round sequencer
// a byte that does not fill the block is taken without a stall, back to back
// a byte that fills the block starts a compression: 64 rounds of the one round unit, then add, then test
// a last item: pad, an extra block when the pad byte lands at or past byte 56, length, final block, then the digest
// input stalls while a compression runs and from a last item through the init step after the fourth word
// arst_n clears the sequencer and loads the md5 initial values; the block buffer is not cleared
module md5_hash_stream_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      msg_valid,
	output logic                      msg_stall,
	input  md5hs_pkg::msg_item_t      msg,
	output logic                      dig_valid,
	input  logic                      dig_stall,
	output md5hs_pkg::digest_item_t   dig
);
	import md5hs_pkg::*;

	pc_t         pc_q, pc_d;
	uword_t      uw;
	logic [5:0]  rnd_q;
	logic [1:0]  idx_q;
	logic        last_q;
	logic [5:0]  fill_q;
	logic [63:0] cnt_q;
	logic [31:0] chain_q [4];
	logic [31:0] blk_q [16];
	logic [31:0] pad_blk [16];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] ra, rb, rc, rd, f, sum, rot, nb;
	logic [4:0]  s;
	logic        msg_acc, dig_acc, full, hold;

	// control word decode
	assign uw        = ucode_rom(pc_q);
	assign msg_stall = (uw.op != OP_WAIT);
	assign dig_valid = (uw.op == OP_EMIT);
	assign msg_acc   = msg_valid && !msg_stall;
	assign dig_acc   = dig_valid && !dig_stall;
	assign full      = msg.byte_valid && (fill_q == 6'd63);

	// output payload straight from the chaining registers
	assign dig.digest_word = chain_q[idx_q];
	assign dig.word_index  = idx_q;
	assign dig.last_word   = (idx_q == 2'd3);

	// sequencer next step
	always_comb begin
		hold = ((uw.op == OP_WAIT) && !msg_acc) ||
		       ((uw.op == OP_ROUND) && (rnd_q != 6'd63)) ||
		       ((uw.op == OP_EMIT) && !(dig_acc && (idx_q == 2'd3)));
		pc_d = pc_q + 4'd1;
		unique case (uw.cond)
			C_STEP: pc_d = pc_q + 4'd1;
			C_ALWAYS: pc_d = uw.target;
			C_NOT_LAST: if (!last_q) pc_d = uw.target;
			C_LT56: if (fill_q < LEN_POS) pc_d = uw.target;
			C_DISPATCH: begin
				if (full) pc_d = PC_BLK_RND;
				else if (msg.last) pc_d = PC_PAD;
				else pc_d = PC_WAIT;
			end
			default: pc_d = PC_WAIT;
		endcase
		if (hold) pc_d = pc_q;
	end

	// round unit: a round 0 starts from the chaining value
	always_comb begin
		ra = (rnd_q == 6'd0) ? chain_q[0] : a_q;
		rb = (rnd_q == 6'd0) ? chain_q[1] : b_q;
		rc = (rnd_q == 6'd0) ? chain_q[2] : c_q;
		rd = (rnd_q == 6'd0) ? chain_q[3] : d_q;
		unique case (rnd_q[5:4])
			2'd0: f = (rb & rc) | (~rb & rd);
			2'd1: f = (rd & rb) | (~rd & rc);
			2'd2: f = rb ^ rc ^ rd;
			2'd3: f = rc ^ (rb | ~rd);
		endcase
		sum = ra + f + ROUND_ADD[rnd_q] + blk_q[msg_index(rnd_q)];
		s   = ROUND_ROT[{rnd_q[5:4], rnd_q[1:0]}];
		rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
		nb  = rb + rot;
	end

	// padding image: 0x80 at the fill position, zeros after it
	always_comb begin
		for (int w = 0; w < 16; w++) begin
			for (int j = 0; j < 4; j++) begin
				if (6'(w * 4 + j) == fill_q) pad_blk[w][8*j +: 8] = PAD_BYTE;
				else if (6'(w * 4 + j) > fill_q) pad_blk[w][8*j +: 8] = 8'h00;
				else pad_blk[w][8*j +: 8] = blk_q[w][8*j +: 8];
			end
		end
	end

	// sequencer and message state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= PC_WAIT;
			rnd_q      <= '0;
			idx_q      <= '0;
			last_q     <= 1'b0;
			fill_q     <= '0;
			cnt_q      <= '0;
			chain_q[0] <= IV0;
			chain_q[1] <= IV1;
			chain_q[2] <= IV2;
			chain_q[3] <= IV3;
		end else begin
			pc_q <= pc_d;
			if (msg_acc) begin
				last_q <= msg.last;
				if (msg.byte_valid) begin
					fill_q <= fill_q + 6'd1;
					cnt_q  <= cnt_q + 64'd8;
				end
			end
			if (uw.op == OP_ROUND) rnd_q <= rnd_q + 6'd1;
			if (dig_acc) idx_q <= idx_q + 2'd1;
			if (uw.op == OP_ADD) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
			end
			if (uw.op == OP_INIT) begin
				fill_q     <= '0;
				cnt_q      <= '0;
				chain_q[0] <= IV0;
				chain_q[1] <= IV1;
				chain_q[2] <= IV2;
				chain_q[3] <= IV3;
			end
		end
	end

	// working variables of the compression
	always_ff @(posedge clk) begin
		if (uw.op == OP_ROUND) begin
			a_q <= rd;
			b_q <= nb;
			c_q <= rb;
			d_q <= rc;
		end
	end

	// block buffer as sixteen little-endian words
	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_WAIT: begin
				if (msg_acc && msg.byte_valid)
					blk_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= msg.data_byte;
			end
			OP_PAD: blk_q <= pad_blk;
			OP_CLEAR: begin
				for (int w = 0; w < 16; w++) blk_q[w] <= '0;
			end
			OP_LEN: begin
				blk_q[14] <= cnt_q[31:0];
				blk_q[15] <= cnt_q[63:32];
			end
			default: ;
		endcase
	end

endmodule

### sv/md5hs_check.sv
// md5hs_check: port-level assertions for md5_hash_stream_unit and their bind
module md5hs_check (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    msg_valid,
	input logic                    msg_stall,
	input md5hs_pkg::msg_item_t    msg,
	input logic                    dig_valid,
	input logic                    dig_stall,
	input md5hs_pkg::digest_item_t dig
);
	// no input transaction while a digest is being delivered
	a_no_input_during_digest: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> msg_stall)
		else $error("input accepted while digest pending");

	// digest words come out in order
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && !dig_stall && !dig.last_word) |=>
		(dig_valid && (dig.word_index == $past(dig.word_index) + 2'd1)))
		else $error("digest word out of order");

	// final flag marks the fourth word only
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (dig.last_word == (dig.word_index == 2'd3)))
		else $error("last_word flag mismatch");

	// digest ends after the final word
	a_digest_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && !dig_stall && dig.last_word) |=> !dig_valid)
		else $error("extra digest transaction");

	// stalled digest word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && dig_stall) |=> (dig_valid && $stable(dig)))
		else $error("stalled digest changed");
endmodule

bind md5_hash_stream_unit md5hs_check u_md5hs_check (.*);
